// File: rtl/tdsc_pkg.sv
// Shared types, codes and decode helpers for the tensor descriptor stride checker.
package tdsc_pkg;

  // Dimension limits
  localparam int MAX_DIMS_DEF = 8;
  localparam int IDX_REACH    = 8;
  localparam int QUEUE_DEPTH  = 2;

  // Result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NDIMS    = 3'd1;
  localparam logic [2:0] ST_DTYPE    = 3'd2;
  localparam logic [2:0] ST_DIM      = 3'd3;
  localparam logic [2:0] ST_NEG      = 3'd4;
  localparam logic [2:0] ST_INCONSIS = 3'd5;
  localparam logic [2:0] ST_PROGRESS = 3'd6;
  localparam logic [2:0] ST_OVERFLOW = 3'd7;

  // Layout order codes
  localparam logic [1:0] ORD_ROW = 2'd0;
  localparam logic [1:0] ORD_COL = 2'd1;

  // Progress kind codes
  localparam logic [1:0] PK_NONE = 2'd0;
  localparam logic [1:0] PK_ROWS = 2'd1;
  localparam logic [1:0] PK_COLS = 2'd2;

  // Input item as it arrives on the port
  typedef struct packed {
    logic [2:0]         dim_index;
    logic signed [31:0] dim_size;
    logic signed [31:0] stride_in;
    logic [3:0]         dtype_code;
    logic [1:0]         order_code;
    logic [7:0]         dim_count;
    logic [1:0]         progress_kind;
    logic [31:0]        progress_stride;
    logic               is_last;
  } tdsc_in_t;

  // Result item
  typedef struct packed {
    logic [2:0]         status;
    logic [2:0]         out_index;
    logic signed [31:0] stride_out;
    logic               last_result;
  } tdsc_out_t;

  // Classified item passed from front to back
  typedef struct packed {
    logic               store_en;
    logic [2:0]         idx;
    logic signed [31:0] dim_size;
    logic signed [31:0] stride_in;
    logic               is_last;
    logic [7:0]         dim_count;
    logic               n_ok;
    logic               dtype_ok;
    logic [3:0]         elem_bytes;
    logic               order_ok;
    logic               order_col;
    logic [1:0]         progress_kind;
    logic [31:0]        progress_stride;
  } tdsc_ent_t;

  // Element size in bytes for a dtype code, zero for an unknown code
  function automatic logic [3:0] elem_bytes(input logic [3:0] code);
    logic [3:0] es;
    if (code <= 4'd4) begin
      es = 4'd1;
    end else if (code <= 4'd6) begin
      es = 4'd2;
    end else if (code <= 4'd9) begin
      es = 4'd4;
    end else if (code <= 4'd12) begin
      es = 4'd8;
    end else begin
      es = 4'd0;
    end
    return es;
  endfunction

endpackage

// File: rtl/tdsc_front.sv
// Front end: accepts input items and classifies them for the back end.
module tdsc_front import tdsc_pkg::*; #(
  parameter int MAX_DIMS = MAX_DIMS_DEF
) (
  input  logic      in_valid,
  output logic      in_stall,
  input  tdsc_in_t  in_item,
  output logic      push_valid,
  input  logic      push_stall,
  output tdsc_ent_t push_ent
);

  localparam int STORE_DEPTH = (MAX_DIMS < IDX_REACH) ? MAX_DIMS : IDX_REACH;

  logic [3:0] es;

  // Stall the input whenever the queue is full
  assign in_stall   = push_stall;
  assign push_valid = in_valid;

  // Decode the item's fields
  always_comb begin
    es = elem_bytes(in_item.dtype_code);
    push_ent.store_en        = (32'(in_item.dim_index) < STORE_DEPTH);
    push_ent.idx             = in_item.dim_index;
    push_ent.dim_size        = in_item.dim_size;
    push_ent.stride_in       = in_item.stride_in;
    push_ent.is_last         = in_item.is_last;
    push_ent.dim_count       = in_item.dim_count;
    push_ent.n_ok            = (in_item.dim_count != 8'd0) &&
                               (32'(in_item.dim_count) <= STORE_DEPTH);
    push_ent.dtype_ok        = (es != 4'd0);
    push_ent.elem_bytes      = es;
    push_ent.order_ok        = (in_item.order_code == ORD_ROW) ||
                               (in_item.order_code == ORD_COL);
    push_ent.order_col       = (in_item.order_code == ORD_COL);
    push_ent.progress_kind   = in_item.progress_kind;
    push_ent.progress_stride = in_item.progress_stride;
  end

endmodule

// File: rtl/tdsc_queue.sv
// Short queue of classified items between front and back.
module tdsc_queue import tdsc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_stall,
  input  tdsc_ent_t push_ent,
  output logic      pop_valid,
  input  logic      pop_ready,
  output tdsc_ent_t pop_ent
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  tdsc_ent_t        mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_stall = (32'(cnt_r) == QUEUE_DEPTH);
  assign pop_valid  = (cnt_r != '0);
  assign pop_ent    = mem[rd_ptr_r];
  assign do_push    = push_valid && !push_stall;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Write the storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_ent;
    end
  end

endmodule

// File: rtl/tdsc_back.sv
// Back end: stores dimensions, runs the checks and the stride fill, emits results.
module tdsc_back import tdsc_pkg::*; #(
  parameter int MAX_DIMS = MAX_DIMS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      pop_valid,
  output logic      pop_ready,
  input  tdsc_ent_t pop_ent,
  output logic      out_valid,
  input  logic      out_stall,
  output tdsc_out_t out_item
);

  localparam int STORE_DEPTH = (MAX_DIMS < IDX_REACH) ? MAX_DIMS : IDX_REACH;
  localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

  // Sequencer states
  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_VAL  = 4'd1;
  localparam logic [3:0] S_INIT = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_DST  = 4'd4;
  localparam logic [3:0] S_PROG = 4'd5;
  localparam logic [3:0] S_PCHK = 4'd6;
  localparam logic [3:0] S_EMIT = 4'd7;
  localparam logic [3:0] S_ERR  = 4'd8;

  localparam logic [61:0] I32_MAX = 62'h7FFF_FFFF;

  // Dimension stores, entries not valid read as zero
  logic signed [31:0]     size_mem   [STORE_DEPTH];
  logic signed [31:0]     stride_mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] valid_r;

  logic [3:0]         state_r, state_nxt;
  logic [IDX_W-1:0]   k_r, k_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [3:0]         es_r, es_nxt;
  logic               order_ok_r, order_ok_nxt;
  logic               order_col_r, order_col_nxt;
  logic [1:0]         pkind_r, pkind_nxt;
  logic [31:0]        pstride_r, pstride_nxt;
  logic signed [31:0] cur_r, cur_nxt;
  logic [61:0]        prod_r, prod_nxt;
  logic [2:0]         err_r, err_nxt;
  logic               out_valid_r, out_valid_nxt;
  tdsc_out_t          out_item_r, out_item_nxt;

  logic               we_size;
  logic               we_stride;
  logic               set_valid;
  logic               clr_valid;
  logic [IDX_W-1:0]   wr_idx;
  logic signed [31:0] wr_size;
  logic signed [31:0] wr_stride;

  logic signed [31:0] rd_size;
  logic signed [31:0] rd_stride;
  logic [IDX_W-1:0]   last_idx;
  logic               at_end;
  logic               out_free;

  assign rd_size   = valid_r[k_r] ? size_mem[k_r] : '0;
  assign rd_stride = valid_r[k_r] ? stride_mem[k_r] : '0;
  assign last_idx  = IDX_W'(n_r - CNT_W'(1));
  assign at_end    = order_col_r ? (k_r == last_idx) : (k_r == '0);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Sequence load, check, fill, progress check and emission
  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    n_nxt         = n_r;
    es_nxt        = es_r;
    order_ok_nxt  = order_ok_r;
    order_col_nxt = order_col_r;
    pkind_nxt     = pkind_r;
    pstride_nxt   = pstride_r;
    cur_nxt       = cur_r;
    prod_nxt      = prod_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    pop_ready     = 1'b0;
    we_size       = 1'b0;
    we_stride     = 1'b0;
    set_valid     = 1'b0;
    clr_valid     = 1'b0;
    wr_idx        = k_r;
    wr_size       = pop_ent.dim_size;
    wr_stride     = pop_ent.stride_in;

    unique case (state_r)
      S_LOAD: begin
        pop_ready = 1'b1;
        wr_idx    = IDX_W'(pop_ent.idx);
        if (pop_valid) begin
          if (pop_ent.store_en) begin
            we_size   = 1'b1;
            we_stride = 1'b1;
            set_valid = 1'b1;
          end
          if (pop_ent.is_last) begin
            n_nxt         = CNT_W'(pop_ent.dim_count);
            es_nxt        = pop_ent.elem_bytes;
            order_ok_nxt  = pop_ent.order_ok;
            order_col_nxt = pop_ent.order_col;
            pkind_nxt     = pop_ent.progress_kind;
            pstride_nxt   = pop_ent.progress_stride;
            k_nxt         = '0;
            if (!pop_ent.n_ok) begin
              err_nxt   = ST_NDIMS;
              state_nxt = S_ERR;
            end else if (!pop_ent.dtype_ok) begin
              err_nxt   = ST_DTYPE;
              state_nxt = S_ERR;
            end else begin
              state_nxt = S_VAL;
            end
          end
        end
      end
      S_VAL: begin
        // Check one dimension per cycle
        if (rd_size <= 32'sd0) begin
          err_nxt   = ST_DIM;
          state_nxt = S_ERR;
        end else if (rd_stride < 32'sd0) begin
          err_nxt   = ST_NEG;
          state_nxt = S_ERR;
        end else if (k_r == last_idx) begin
          if (!order_ok_r) begin
            err_nxt   = ST_INCONSIS;
            state_nxt = S_ERR;
          end else begin
            k_nxt     = order_col_r ? '0 : last_idx;
            state_nxt = S_INIT;
          end
        end else begin
          k_nxt = k_r + IDX_W'(1);
        end
      end
      S_INIT: begin
        // Seed the innermost stride with the element size when it is zero
        if (rd_stride == 32'sd0) begin
          cur_nxt   = signed'({28'd0, es_r});
          wr_stride = signed'({28'd0, es_r});
          we_stride = 1'b1;
        end else begin
          cur_nxt = rd_stride;
        end
        state_nxt = at_end ? S_PROG : S_MUL;
      end
      S_MUL: begin
        prod_nxt  = cur_r[30:0] * rd_size[30:0];
        k_nxt     = order_col_r ? k_r + IDX_W'(1) : k_r - IDX_W'(1);
        state_nxt = S_DST;
      end
      S_DST: begin
        // Fill or confirm the next stride against the packed product
        if (prod_r > I32_MAX) begin
          err_nxt   = ST_OVERFLOW;
          state_nxt = S_ERR;
        end else if (rd_stride == 32'sd0) begin
          cur_nxt   = signed'(prod_r[31:0]);
          wr_stride = signed'(prod_r[31:0]);
          we_stride = 1'b1;
          state_nxt = at_end ? S_PROG : S_MUL;
        end else if ($unsigned(rd_stride) < prod_r[31:0]) begin
          err_nxt   = ST_INCONSIS;
          state_nxt = S_ERR;
        end else begin
          cur_nxt   = rd_stride;
          state_nxt = at_end ? S_PROG : S_MUL;
        end
      end
      S_PROG: begin
        if (pkind_r == PK_NONE) begin
          k_nxt     = '0;
          state_nxt = S_EMIT;
        end else if ((pstride_r == 32'd0) ||
                     ((pkind_r != PK_ROWS) && (pkind_r != PK_COLS)) ||
                     ((pkind_r == PK_COLS) && (n_r <= CNT_W'(1)))) begin
          err_nxt   = ST_PROGRESS;
          state_nxt = S_ERR;
        end else begin
          k_nxt     = (pkind_r == PK_COLS) ? IDX_W'(1) : '0;
          state_nxt = S_PCHK;
        end
      end
      S_PCHK: begin
        if ($unsigned(rd_stride) != pstride_r) begin
          err_nxt   = ST_PROGRESS;
          state_nxt = S_ERR;
        end else begin
          k_nxt     = '0;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        // Emit one stride per dimension as the output frees up
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_item_nxt.status      = ST_OK;
          out_item_nxt.out_index   = 3'(k_r);
          out_item_nxt.stride_out  = rd_stride;
          out_item_nxt.last_result = (k_r == last_idx);
          if (k_r == last_idx) begin
            clr_valid = 1'b1;
            state_nxt = S_LOAD;
          end else begin
            k_nxt = k_r + IDX_W'(1);
          end
        end
      end
      S_ERR: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_item_nxt.status      = err_r;
          out_item_nxt.out_index   = 3'd0;
          out_item_nxt.stride_out  = '0;
          out_item_nxt.last_result = 1'b1;
          clr_valid                = 1'b1;
          state_nxt                = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (clr_valid) begin
        valid_r <= '0;
      end else if (set_valid) begin
        valid_r[wr_idx] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    k_r         <= k_nxt;
    n_r         <= n_nxt;
    es_r        <= es_nxt;
    order_ok_r  <= order_ok_nxt;
    order_col_r <= order_col_nxt;
    pkind_r     <= pkind_nxt;
    pstride_r   <= pstride_nxt;
    cur_r       <= cur_nxt;
    prod_r      <= prod_nxt;
    err_r       <= err_nxt;
    out_item_r  <= out_item_nxt;
  end

  // Dimension store writes
  always_ff @(posedge clk) begin
    if (we_size) begin
      size_mem[wr_idx] <= wr_size;
    end
    if (we_stride) begin
      stride_mem[wr_idx] <= wr_stride;
    end
  end

endmodule

// File: rtl/tensor_descriptor_stride_checker.sv
// Top level of the tensor descriptor stride checker.
//
// Usage: send a descriptor on the in_ channel, one item per dimension, with
// dim_index, dim_size and stride_in (zero asks for a filled stride). The item
// with is_last set also carries dtype, order, dimension count and progress
// fields and starts the check. Results leave on the out_ channel: one item per
// dimension with its final stride (last_result on the final one), or a single
// error item. Both channels use valid/stall; an item moves when valid is high
// and stall is low.
// A non-last item is stored in the load state and the back end can take the
// next item straight away. A last item holds the back end through the load, a
// check of each dimension, a seed step, a fill step for each further
// dimension (multiply, then compare and write), the progress decode and
// check, and one output per dimension. An error ends the walk early. Each
// item passes through a two-entry queue, which lets the next items enter.
// Reset clears the queue, the stores' valid bits and the output valid flag.
// A stalled receiver holds the result register and the back end waits.
module tensor_descriptor_stride_checker import tdsc_pkg::*; #(
  parameter int MAX_DIMS = MAX_DIMS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  tdsc_in_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output tdsc_out_t out_item
);

  logic      push_valid;
  logic      push_stall;
  tdsc_ent_t push_ent;
  logic      pop_valid;
  logic      pop_ready;
  tdsc_ent_t pop_ent;

  // Classify incoming items
  tdsc_front #(.MAX_DIMS(MAX_DIMS)) u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_ent   (push_ent)
  );

  // Buffer classified items
  tdsc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_ent   (push_ent),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_ent    (pop_ent)
  );

  // Store, check, fill and emit
  tdsc_back #(.MAX_DIMS(MAX_DIMS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_ent   (pop_ent),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// File: verif/tdsc_result_check.sv
// Result checker for the tensor descriptor stride checker: predicts strides and compares results.
module tdsc_result_check import tdsc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  tdsc_in_t  in_item,
  input  logic      out_valid,
  input  logic      out_stall,
  input  tdsc_out_t out_item,
  output int        mismatches,
  output int        pending,
  output int        checked,
  output logic [7:0] codes_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM_SLOTS  = 8;
  localparam int REPORT_MAX = 10;

  // Descriptor being loaded, widened so products cannot wrap
  longint dim_len   [DIM_SLOTS];
  longint dim_pitch [DIM_SLOTS];

  // Results still owed by the block, oldest first
  tdsc_out_t owed_results [$];

  int         fail_cnt;
  int         match_cnt;
  logic [7:0] code_mask;

  function automatic int width_bytes(input logic [3:0] code);
    if (code > 4'd12) return 0;
    if (code > 4'd9) return 8;
    if (code > 4'd6) return 4;
    if (code > 4'd4) return 2;
    return 1;
  endfunction

  // Fill or confirm the stride of dst from the packed extent of src
  function automatic logic [2:0] fill_step(input int dst, input int src);
    longint dense;
    dense = dim_pitch[src] * dim_len[src];
    if (dense > 64'sd2147483647) return ST_OVERFLOW;
    if (dim_pitch[dst] == 0) begin
      dim_pitch[dst] = dense;
    end else if (dim_pitch[dst] < dense) begin
      return ST_INCONSIS;
    end
    return ST_OK;
  endfunction

  // Run the full descriptor check; strides are filled in place
  function automatic logic [2:0] check_descriptor(input int n, input logic [3:0] dtype,
                                                  input logic [1:0] order,
                                                  input logic [1:0] pk,
                                                  input logic [31:0] ps);
    longint     es;
    logic [2:0] st;
    int         i;
    if (n == 0 || n > DIM_SLOTS) return ST_NDIMS;
    es = width_bytes(dtype);
    if (es == 0) return ST_DTYPE;
    for (i = 0; i < n; i++) begin
      if (dim_len[i] <= 0) return ST_DIM;
      if (dim_pitch[i] < 0) return ST_NEG;
    end
    if (order == ORD_ROW) begin
      if (dim_pitch[n-1] == 0) dim_pitch[n-1] = es;
      for (i = n - 1; i > 0; i--) begin
        st = fill_step(i - 1, i);
        if (st != ST_OK) return st;
      end
    end else if (order == ORD_COL) begin
      if (dim_pitch[0] == 0) dim_pitch[0] = es;
      for (i = 1; i < n; i++) begin
        st = fill_step(i, i - 1);
        if (st != ST_OK) return st;
      end
    end else begin
      return ST_INCONSIS;
    end
    // Progress stride must match the outer row or column pitch
    if (pk == PK_NONE) return ST_OK;
    if (ps == 32'd0) return ST_PROGRESS;
    if (pk == PK_ROWS) begin
      return (dim_pitch[0] == longint'({32'd0, ps})) ? ST_OK : ST_PROGRESS;
    end
    if (pk == PK_COLS) begin
      return (n >= 2 && dim_pitch[1] == longint'({32'd0, ps})) ? ST_OK : ST_PROGRESS;
    end
    return ST_PROGRESS;
  endfunction

  function automatic void clear_descriptor();
    foreach (dim_len[i]) begin
      dim_len[i]   = 0;
      dim_pitch[i] = 0;
    end
  endfunction

  // Store one dimension; on the last item queue the owed results
  function automatic void take_item(input tdsc_in_t it);
    int         n;
    logic [2:0] st;
    tdsc_out_t  r;
    dim_len[it.dim_index]   = longint'(it.dim_size);
    dim_pitch[it.dim_index] = longint'(it.stride_in);
    if (!it.is_last) return;
    n  = int'(it.dim_count);
    st = check_descriptor(n, it.dtype_code, it.order_code, it.progress_kind,
                          it.progress_stride);
    code_mask[st] = 1'b1;
    if (st != ST_OK) begin
      r.status      = st;
      r.out_index   = 3'd0;
      r.stride_out  = 32'sd0;
      r.last_result = 1'b1;
      owed_results.push_back(r);
    end else begin
      for (int i = 0; i < n; i++) begin
        r.status      = ST_OK;
        r.out_index   = 3'(i);
        r.stride_out  = dim_pitch[i][31:0];
        r.last_result = (i == n - 1);
        owed_results.push_back(r);
      end
    end
    clear_descriptor();
  endfunction

  // Compare one result with the oldest owed one
  function automatic void match_result(input tdsc_out_t got);
    tdsc_out_t want;
    if (owed_results.size() == 0) begin
      fail_cnt++;
      if (fail_cnt <= REPORT_MAX) begin
        $display("unexpected result: status %0d index %0d stride %0d last %0b",
                 got.status, got.out_index, got.stride_out, got.last_result);
      end
      return;
    end
    want = owed_results.pop_front();
    match_cnt++;
    if (got.status !== want.status || got.out_index !== want.out_index ||
        got.stride_out !== want.stride_out || got.last_result !== want.last_result) begin
      fail_cnt++;
      if (fail_cnt <= REPORT_MAX) begin
        $display("result mismatch: expected status %0d index %0d stride %0d last %0b",
                 want.status, want.out_index, want.stride_out, want.last_result);
        $display("                 actual   status %0d index %0d stride %0d last %0b",
                 got.status, got.out_index, got.stride_out, got.last_result);
      end
    end
  endfunction

  // Watch both channels; results leave before a new item can affect them
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_descriptor();
      owed_results.delete();
      fail_cnt  = 0;
      match_cnt = 0;
      code_mask = 8'd0;
    end else begin
      if (out_valid && !out_stall) match_result(out_item);
      if (in_valid && !in_stall) take_item(in_item);
    end
    mismatches <= fail_cnt;
    pending    <= owed_results.size();
    checked    <= match_cnt;
    codes_seen <= code_mask;
  end

endmodule

// File: verif/tensor_descriptor_stride_checker_tb.sv
// Testbench top for the tensor descriptor stride checker: stimulus, stalls and verdict.
module tensor_descriptor_stride_checker_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tdsc_pkg::*;

  localparam int ITEMS       = 330;
  localparam int IDLE_PCT    = 28;
  localparam int CALM_FIRST  = 150;
  localparam int CALM_END    = 215;
  localparam int HOLD_AFTER  = 40;
  localparam int HOLD_CYCLES = 150;
  localparam int TAIL_CYCLES = 60;
  localparam int LIMIT_NS    = 400000;

  // Element type codes at the edges of each size group
  localparam logic [3:0] DT_FIRST_1B = 4'd0;
  localparam logic [3:0] DT_FIRST_2B = 4'd5;
  localparam logic [3:0] DT_FIRST_4B = 4'd7;
  localparam logic [3:0] DT_FIRST_8B = 4'd10;
  localparam logic [3:0] DT_LAST_8B  = 4'd12;
  localparam logic [3:0] DT_BAD      = 4'd13;
  localparam logic [3:0] DT_TOP      = 4'd15;
  localparam logic [1:0] ORD_BAD     = 2'd2;
  localparam logic [1:0] PK_BAD      = 2'd3;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  tdsc_in_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  tdsc_out_t out_item;

  int         mismatches;
  int         pending;
  int         checked;
  logic [7:0] codes_seen;

  int  items_sent  = 0;
  int  descriptors = 0;
  logic calm       = 1'b0;

  tensor_descriptor_stride_checker u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  tdsc_result_check u_result_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked),
    .codes_seen (codes_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // End the run if the block hangs
  initial begin
    #(LIMIT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic tdsc_in_t random_item();
    tdsc_in_t it;
    it.dim_index       = 3'($urandom_range(7));
    it.dim_size        = $urandom;
    it.stride_in       = $urandom;
    it.dtype_code      = 4'($urandom_range(15));
    it.order_code      = 2'($urandom_range(3));
    it.dim_count       = 8'($urandom_range(255));
    it.progress_kind   = 2'($urandom_range(3));
    it.progress_stride = $urandom;
    it.is_last         = 1'($urandom_range(1));
    return it;
  endfunction

  // Non-last item: descriptor-wide fields are ignored, so keep them random
  function automatic tdsc_in_t dim_item(input logic [2:0] idx, input logic [31:0] size,
                                        input logic [31:0] stride);
    tdsc_in_t it;
    it           = random_item();
    it.dim_index = idx;
    it.dim_size  = size;
    it.stride_in = stride;
    it.is_last   = 1'b0;
    return it;
  endfunction

  function automatic tdsc_in_t last_item(input logic [2:0] idx, input logic [31:0] size,
                                         input logic [31:0] stride, input logic [3:0] dtype,
                                         input logic [1:0] order, input logic [7:0] cnt,
                                         input logic [1:0] pk, input logic [31:0] ps);
    tdsc_in_t it;
    it                 = dim_item(idx, size, stride);
    it.dtype_code      = dtype;
    it.order_code      = order;
    it.dim_count       = cnt;
    it.progress_kind   = pk;
    it.progress_stride = ps;
    it.is_last         = 1'b1;
    return it;
  endfunction

  // Offer one item, after a random gap outside the calm stretch, and hold it until accepted
  task automatic send_item(input tdsc_in_t it);
    calm <= (items_sent >= CALM_FIRST && items_sent < CALM_END);
    if (items_sent < CALM_FIRST || items_sent >= CALM_END) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (it.is_last) descriptors++;
  endtask

  // Build a descriptor in fill order so explicit strides are mostly legal
  task automatic send_descriptor(input bit broken);
    int          n, k, i, fault;
    logic [3:0]  dtype;
    logic [1:0]  order, pk;
    logic [7:0]  cnt;
    logic [31:0] ps;
    longint      es, run, pad;
    longint      len   [8];
    longint      pitch [8];
    longint      eff   [8];
    bit          down;
    tdsc_in_t    it;
    n     = ($urandom_range(7) == 0) ? 8 : int'($urandom_range(4, 1));
    dtype = 4'($urandom_range(DT_LAST_8B));
    es    = (dtype < DT_FIRST_2B) ? 1 : (dtype < DT_FIRST_4B) ? 2 :
            (dtype < DT_FIRST_8B) ? 4 : 8;
    order = $urandom_range(1) ? ORD_COL : ORD_ROW;
    for (i = 0; i < 8; i++) begin
      len[i] = ($urandom_range(15) == 0) ? longint'($urandom_range(32'h7fffffff, 1))
                                         : longint'($urandom_range(12, 1));
      pitch[i] = 0;
      eff[i]   = 0;
    end
    run = es;
    for (k = 0; k < n; k++) begin
      i   = (order == ORD_COL) ? k : n - 1 - k;
      pad = es * longint'($urandom_range(4));
      if ($urandom_range(9) < 6 || run + pad > 64'sd2147483647) begin
        pitch[i] = 0;
        eff[i]   = run;
      end else begin
        pitch[i] = run + pad;
        eff[i]   = pitch[i];
      end
      run = eff[i] * len[i];
      // past this point the walk overflows anyway; keep the product bounded
      if (run > 64'sd2147483647) run = 64'sd2147483648;
    end
    pk  = 2'($urandom_range(2));
    ps  = $urandom;
    cnt = 8'(n);
    if (pk == PK_ROWS) begin
      ps = eff[0][31:0];
    end else if (pk == PK_COLS && n >= 2) begin
      ps = eff[1][31:0];
    end
    // Break one aspect of the descriptor
    if (broken) begin
      fault = $urandom_range(7);
      i     = $urandom_range(n - 1);
      case (fault)
        0: len[i] = -longint'($urandom_range(32'h7fffffff));
        1: pitch[i] = -longint'($urandom_range(32'h7fffffff, 1));
        2: pitch[i] = longint'($urandom_range(3, 1));
        3: dtype = 4'($urandom_range(DT_TOP, DT_BAD));
        4: order = 2'($urandom_range(PK_BAD, ORD_BAD));
        5: cnt = $urandom_range(1) ? 8'd0 : 8'($urandom_range(255, 9));
        6: begin
          pk = 2'($urandom_range(PK_BAD, PK_ROWS));
          ps = $urandom_range(1) ? 32'd0 : (ps ^ (32'd1 << $urandom_range(31)));
        end
        default: begin
          if (n < 8) cnt = 8'(n + 1);
          else len[i] = 0;
        end
      endcase
    end
    down = 1'($urandom_range(1));
    for (k = 0; k < n; k++) begin
      i = down ? n - 1 - k : k;
      if (k == n - 1) begin
        it = last_item(3'(i), len[i][31:0], pitch[i][31:0], dtype, order, cnt, pk, ps);
      end else begin
        it = dim_item(3'(i), len[i][31:0], pitch[i][31:0]);
      end
      send_item(it);
    end
  endtask

  // Receiver: random stalls, one long hold-off, and a calm stretch
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 0;
    forever begin
      @(posedge clk);
      if (!hold_done && checked >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int       pick;
    tdsc_in_t it;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // three dimensions row-major, 8-byte elements, rows progress
    send_item(dim_item(3'd2, 32'd4, 32'd0));
    send_item(dim_item(3'd1, 32'd3, 32'd0));
    send_item(last_item(3'd0, 32'd2, 32'd0, DT_LAST_8B, ORD_ROW, 8'd3, PK_ROWS, 32'd96));
    // two dimensions column-major, 2-byte elements, columns progress
    send_item(dim_item(3'd0, 32'd5, 32'd0));
    send_item(last_item(3'd1, 32'd7, 32'd0, DT_FIRST_2B, ORD_COL, 8'd2, PK_COLS, 32'd10));
    // dimension count of zero and beyond the store
    send_item(last_item(3'd0, 32'd1, 32'd0, DT_FIRST_1B, ORD_ROW, 8'd0, PK_NONE, 32'd0));
    send_item(last_item(3'd0, 32'd1, 32'd0, DT_FIRST_1B, ORD_ROW, 8'd9, PK_NONE, 32'd0));
    // unknown dtype
    send_item(last_item(3'd0, 32'd1, 32'd0, DT_TOP, ORD_ROW, 8'd1, PK_NONE, 32'd0));
    // most negative size
    send_item(last_item(3'd0, 32'h80000000, 32'd0, DT_FIRST_1B, ORD_ROW, 8'd1, PK_NONE,
                        32'd0));
    // dimension 0 never written in this descriptor
    send_item(last_item(3'd1, 32'd3, 32'd0, DT_FIRST_1B, ORD_ROW, 8'd2, PK_NONE, 32'd0));
    // negative stride
    send_item(last_item(3'd0, 32'd1, 32'hffffffff, DT_FIRST_1B, ORD_ROW, 8'd1, PK_NONE,
                        32'd0));
    // invalid order
    send_item(last_item(3'd0, 32'd1, 32'd0, DT_FIRST_1B, ORD_BAD, 8'd1, PK_NONE, 32'd0));
    // explicit stride below the packed one
    send_item(dim_item(3'd1, 32'd10, 32'd0));
    send_item(last_item(3'd0, 32'd1, 32'd8, DT_FIRST_4B, ORD_ROW, 8'd2, PK_NONE, 32'd0));
    // packed product beyond 32 bits
    send_item(dim_item(3'd1, 32'h7fffffff, 32'd0));
    send_item(last_item(3'd0, 32'd1, 32'd0, DT_FIRST_8B, ORD_ROW, 8'd2, PK_NONE, 32'd0));
    // progress: invalid kind, columns with one dimension, zero stride
    send_item(last_item(3'd0, 32'd1, 32'd0, DT_FIRST_1B, ORD_ROW, 8'd1, PK_BAD, 32'd1));
    send_item(last_item(3'd0, 32'd1, 32'd0, DT_FIRST_1B, ORD_ROW, 8'd1, PK_COLS, 32'd1));
    send_item(last_item(3'd0, 32'd1, 32'd0, DT_FIRST_1B, ORD_ROW, 8'd1, PK_ROWS, 32'd0));
    // all eight dimensions, largest explicit stride on the outer one
    for (int d = 0; d < 7; d++) begin
      send_item(dim_item(3'(d), 32'd2, 32'd0));
    end
    send_item(last_item(3'd7, 32'd2, 32'h7fffffff, DT_FIRST_8B - 4'd1, ORD_COL, 8'd8,
                        PK_COLS, 32'd8));

    // Mostly legal descriptors, some broken ones, some loose items
    while (items_sent < ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 72) begin
        send_descriptor(1'b0);
      end else if (pick < 87) begin
        send_descriptor(1'b1);
      end else begin
        it         = random_item();
        it.is_last = ($urandom_range(3) == 0);
        send_item(it);
      end
    end
    in_valid <= 1'b0;

    // Drain, then allow for a late or extra result
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d items in %0d descriptors, %0d results checked",
             items_sent, descriptors, checked);
    $display("status codes produced (bit per code, code 0 rightmost): %08b", codes_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/tdsc_pkg.sv
rtl/tdsc_front.sv
rtl/tdsc_queue.sv
rtl/tdsc_back.sv
rtl/tensor_descriptor_stride_checker.sv
verif/tdsc_result_check.sv
verif/tensor_descriptor_stride_checker_tb.sv
